// ----- hw/rtl/best_partition_result_select_defines.svh -----
// assertion macros for the best partition result select block
`ifndef BEST_PARTITION_RESULT_SELECT_DEFINES_SVH
`define BEST_PARTITION_RESULT_SELECT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BPRS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BPRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bprs_pkg.sv -----
// types and constants shared by the best partition result select block
`default_nettype none

package bprs_pkg;

    localparam int MAX_CANDIDATES = 256;
    localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W          = 8;
    localparam int CUT_W          = 32;
    localparam int IMB_W          = 32;

    typedef struct packed {
        logic [CUT_W-1:0] cut_weight;
        logic             bal_flag;
        logic [IMB_W-1:0] imbalance;
        logic             last;
    } cand_t;

    typedef struct packed {
        logic [IDX_W-1:0] best_index;
        logic             chose_balanced;
        logic             overflow;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bprs_tracker.sv -----
// running-best tracker over one run of candidates
`default_nettype none

`include "best_partition_result_select_defines.svh"

module bprs_tracker
    import bprs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    take,
    input  wire cand_t   cand,
    output result_t      res
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             seen_bal_reg, seen_bal_next;
    logic [IDX_W-1:0] first_bal_idx_reg, first_bal_idx_next;
    logic             seen_nz_reg, seen_nz_next;
    logic [IDX_W-1:0] best_bal_idx_reg, best_bal_idx_next;
    logic [CUT_W-1:0] best_bal_cut_reg, best_bal_cut_next;
    logic             seen_unb_reg, seen_unb_next;
    logic [IDX_W-1:0] best_unb_idx_reg, best_unb_idx_next;
    logic [IMB_W-1:0] best_unb_imb_reg, best_unb_imb_next;
    logic [CUT_W-1:0] best_unb_cut_reg, best_unb_cut_next;

    logic             full;
    logic             use_cand;
    logic [IDX_W-1:0] pos;

    assign full     = (count_reg == CNT_W'(MAX_CANDIDATES));
    assign use_cand = take && !full;
    assign pos      = IDX_W'(count_reg);

    always_comb begin
        count_next         = count_reg;
        seen_bal_next      = seen_bal_reg;
        first_bal_idx_next = first_bal_idx_reg;
        seen_nz_next       = seen_nz_reg;
        best_bal_idx_next  = best_bal_idx_reg;
        best_bal_cut_next  = best_bal_cut_reg;
        seen_unb_next      = seen_unb_reg;
        best_unb_idx_next  = best_unb_idx_reg;
        best_unb_imb_next  = best_unb_imb_reg;
        best_unb_cut_next  = best_unb_cut_reg;

        if (use_cand) begin
            count_next = count_reg + CNT_W'(1);
            if (cand.bal_flag) begin
                if (!seen_bal_reg) begin
                    seen_bal_next      = 1'b1;
                    first_bal_idx_next = pos;
                end
                if ((cand.cut_weight != '0) &&
                    (!seen_nz_reg || (cand.cut_weight < best_bal_cut_reg))) begin
                    seen_nz_next      = 1'b1;
                    best_bal_idx_next = pos;
                    best_bal_cut_next = cand.cut_weight;
                end
            end else begin
                if (!seen_unb_reg || (cand.imbalance < best_unb_imb_reg) ||
                    ((cand.imbalance == best_unb_imb_reg) &&
                     (cand.cut_weight < best_unb_cut_reg))) begin
                    seen_unb_next     = 1'b1;
                    best_unb_idx_next = pos;
                    best_unb_imb_next = cand.imbalance;
                    best_unb_cut_next = cand.cut_weight;
                end
            end
        end

        // result of the run, valid when the last beat is taken
        res.chose_balanced = seen_bal_next;
        res.overflow       = full;
        if (seen_bal_next) begin
            res.best_index = seen_nz_next ? best_bal_idx_next : first_bal_idx_next;
        end else begin
            res.best_index = best_unb_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && cand.last)) begin
            count_reg         <= '0;
            seen_bal_reg      <= 1'b0;
            first_bal_idx_reg <= '0;
            seen_nz_reg       <= 1'b0;
            best_bal_idx_reg  <= '0;
            best_bal_cut_reg  <= '0;
            seen_unb_reg      <= 1'b0;
            best_unb_idx_reg  <= '0;
            best_unb_imb_reg  <= '0;
            best_unb_cut_reg  <= '0;
        end else begin
            count_reg         <= count_next;
            seen_bal_reg      <= seen_bal_next;
            first_bal_idx_reg <= first_bal_idx_next;
            seen_nz_reg       <= seen_nz_next;
            best_bal_idx_reg  <= best_bal_idx_next;
            best_bal_cut_reg  <= best_bal_cut_next;
            seen_unb_reg      <= seen_unb_next;
            best_unb_idx_reg  <= best_unb_idx_next;
            best_unb_imb_reg  <= best_unb_imb_next;
            best_unb_cut_reg  <= best_unb_cut_next;
        end
    end

    `BPRS_ASSERT_NOW(a_count_in_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_CANDIDATES), "candidate count beyond limit")
    `BPRS_ASSERT_NEXT(a_run_cleared, aclk, aresetn, take && cand.last, count_reg == '0 && !seen_bal_reg && !seen_unb_reg, "run state not cleared after last beat")

endmodule

`default_nettype wire

// ----- hw/rtl/best_partition_result_select.sv -----
// top level of the best partition result select block
//
//  channel | dir | tdata                                | tuser                           | tlast
//  s_      | in  | [31:0] cut_weight, [63:32] imbalance | [0] bal_flag                    | last
//  m_      | out | [7:0] best_index                     | [0] chose_balanced [1] overflow | -
//
// one input beat per cycle; each beat is registered, then compared combinationally against
// the running bests, and the last beat of a run loads the result register
// a result is loaded from the running bests as its last beat leaves the input register
// input keeps flowing while a result waits, only a last beat stalls on a full
// result register
// aresetn is synchronous and clears the run state and both valid flags
`default_nettype none

`include "best_partition_result_select_defines.svh"

module best_partition_result_select
    import bprs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // cut_weight, imbalance
    input  wire logic [0:0]  s_tuser,  // bal_flag
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // best_index
    output logic [1:0]       m_tuser   // chose_balanced, overflow
);

    logic    in_valid_reg;
    cand_t   in_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;
    logic    out_free;
    logic    advance;
    logic    s_beat;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_reg.last || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    bprs_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (advance),
        .cand    (in_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_beat) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && in_reg.last) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_reg.cut_weight <= s_tdata[31:0];
            in_reg.imbalance  <= s_tdata[63:32];
            in_reg.bal_flag   <= s_tuser[0];
            in_reg.last       <= s_tlast;
        end
        if (advance && in_reg.last) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.best_index;
    assign m_tuser  = {out_reg.overflow, out_reg.chose_balanced};

    `BPRS_ASSERT_NOW(a_stall_only_when_held, aclk, aresetn, !s_tready, in_valid_reg && in_reg.last && out_valid_reg, "input stalled without a waiting last beat")
    `BPRS_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, advance && in_reg.last, out_valid_reg, "last beat did not load a result")
    `BPRS_ASSERT_NEXT(a_result_not_dropped, aclk, aresetn, out_valid_reg && !m_tready, out_valid_reg && $stable(out_reg), "waiting result lost or changed")

endmodule

`default_nettype wire
